>>> src/ip_port_list_filter_top_assert.svh
// Assertion macros for the port list filter.
`ifndef IP_PORT_LIST_FILTER_TOP_ASSERT_SVH
`define IP_PORT_LIST_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IPLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/iplf_pkg.sv
`default_nettype none

package iplf_pkg;

    // Operation codes
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Protocols that carry a source port
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [7:0]  protocol;
        logic        new_mode;
    } in_item_t;

    typedef struct packed {
        logic verdict;
        logic table_full;
    } out_item_t;

    // One table entry, also the lookup key
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> src/iplf_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module iplf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/ip_port_list_filter_top.sv
// Check: one table entry compared per cycle; the scan stops at the fill count, or earlier on
// a match near the head. Add, clear and unused codes go straight to the result. One item at
// a time: the next item can be taken in the same cycle the result appears; a stalled result
// delays it.
// Reset (aresetn low, synchronous) empties the table and selects blacklist mode;
// table RAM contents are not cleared, entries above the fill count are never read.
`default_nettype none

module ip_port_list_filter_top #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire iplf_pkg::in_item_t s_data,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      iplf_pkg::out_item_t m_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 mode_reg, mode_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 pend_reg, pend_next;
    logic                 hit_reg, hit_next;
    logic                 full_reg, full_next;
    logic [1:0]           op_reg, op_next;
    iplf_pkg::entry_t     key_reg, key_next;
    logic                 m_valid_reg, m_valid_next;
    iplf_pkg::out_item_t  m_data_reg, m_data_next;

    logic                 ram_we;
    iplf_pkg::entry_t     ram_wdata;
    logic [iplf_pkg::ENTRY_W-1:0] ram_rdata;
    logic                 issue;
    logic                 port_used;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Entry to store on add: port as given, protocol ignored
    assign ram_wdata.addr = s_data.source_ip;
    assign ram_wdata.port = s_data.source_port;

    assign port_used = (s_data.protocol == iplf_pkg::PROTO_TCP) ||
                       (s_data.protocol == iplf_pkg::PROTO_UDP);

    // Scan reads one entry per cycle until the fill count or a hit
    assign issue = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg) && !hit_reg;

    iplf_ram #(
        .WIDTH (iplf_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        mode_next    = mode_reg;
        rd_idx_next  = rd_idx_reg;
        pend_next    = pend_reg;
        hit_next     = hit_reg;
        full_next    = full_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_data.op;
                    key_next.addr = s_data.source_ip;
                    key_next.port = port_used ? s_data.source_port : 16'd0;
                    full_next     = 1'b0;
                    hit_next      = 1'b0;
                    pend_next     = 1'b0;
                    rd_idx_next   = '0;
                    state_next    = ST_DONE;
                    case (s_data.op)
                        iplf_pkg::OP_CHECK: begin
                            state_next = ST_SCAN;
                        end
                        iplf_pkg::OP_ADD: begin
                            if (count_reg == DEPTH_CNT) begin
                                full_next = 1'b1;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        iplf_pkg::OP_CLEAR: begin
                            count_next = '0;
                            mode_next  = s_data.new_mode;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                pend_next = issue;
                if (issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                // read data arrives in the cycle after its address
                if (pend_reg && (ram_rdata == key_reg)) begin
                    hit_next = 1'b1;
                end
                if (hit_reg || (!issue && !pend_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.verdict    = (op_reg == iplf_pkg::OP_CHECK) ?
                                             (hit_reg ^ mode_reg) : 1'b0;
                    m_data_next.table_full = full_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            mode_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            mode_reg    <= mode_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            full_reg    <= full_next;
            m_valid_reg <= m_valid_next;
            op_reg      <= op_next;
            key_reg     <= key_next;
            m_data_reg  <= m_data_next;
        end
    end

    // Checks
    `include "ip_port_list_filter_top_assert.svh"

    `IPLF_ASSERT_NEXT(a_clear_empties, s_valid && s_ready && (s_data.op == iplf_pkg::OP_CLEAR), count_reg == '0 && mode_reg == $past(s_data.new_mode), "clear did not empty the table")
    `IPLF_ASSERT_NEXT(a_add_grows, s_valid && s_ready && (s_data.op == iplf_pkg::OP_ADD) && (count_reg != DEPTH_CNT), count_reg == $past(count_reg) + 1'b1, "add did not store an entry")
    `IPLF_ASSERT_NEXT(a_full_holds, s_valid && s_ready && (s_data.op == iplf_pkg::OP_ADD) && (count_reg == DEPTH_CNT), $stable(count_reg) && full_reg, "add to a full table changed the count")
    `IPLF_ASSERT_NOW(a_scan_bound, state_reg == ST_SCAN, rd_idx_reg <= count_reg, "scan ran past the fill count")

endmodule

`default_nettype wire
